[rtl/pars_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pars_pkg
// Shared types and codes of the positional array with range sum.
// ----------------------------------------------------------------------------
package pars_pkg;

  // Width of one stored entry
  localparam int unsigned ValW = 32;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_ERASE     = 3'd2,
    ACT_OVERWRITE = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_SUM       = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_POS   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage
`default_nettype wire

[rtl/pars_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pars_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pars_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/positional_array_range_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_range_sum
// Positional array of signed entries with insert, erase, overwrite, read,
// clear and exact range sum, built on one RAM and a small sequencer.
// ----------------------------------------------------------------------------
// Usage: raise start with the item on action_i, index_i, right_index_i and
// value_i; the item is taken at a clock edge where busy is low. Exactly one
// result follows, shown for a single cycle with valid_o high; the receiver
// cannot stall it, so it must take the result in that cycle. count_o and
// is_empty_o hold the count after the action. Clear, overwrite, insert at
// the end, erase of the last entry, undefined actions and every rejected
// item finish without leaving idle and leave busy low, so the next item may
// follow at once. Read waits in its own state for the registered RAM read.
// Insert with shifting walks down from the last entry to the index, then
// writes the new value; erase with shifting walks up from the entry after the
// index to the last entry; a range sum walks from index to right_index. Each
// shift step or summed entry costs one RAM read on the single port pair, and
// the read data is written back or added in the next cycle, overlapped with
// the next read. The RAM is never cleared; only entries below the count are
// ever used.
// ----------------------------------------------------------------------------
module positional_array_range_sum #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [2:0]                                action_i,
  input  logic [$clog2(DEPTH+1)-1:0]                index_i,
  input  logic [$clog2(DEPTH)-1:0]                  right_index_i,
  input  logic signed [pars_pkg::ValW-1:0]          value_i,
  output logic                                      valid_o,
  output logic signed [pars_pkg::ValW+$clog2(DEPTH)-1:0] data_o,
  output logic [$clog2(DEPTH+1)-1:0]                count_o,
  output logic                                      is_empty_o,
  output logic [1:0]                                status_o
);

  import pars_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned DataW = ValW + AddrW;

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_WAIT = 3'd1;
  localparam logic [2:0] S_RUN     = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_INS_WR  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  action_e                 op_q, op_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic [ValW-1:0]         val_q, val_d;
  logic [AddrW-1:0]        ptr_q, ptr_d;
  logic [AddrW-1:0]        end_q, end_d;
  logic [AddrW-1:0]        wr_addr_q, wr_addr_d;
  logic                    pend_q, pend_d;
  logic signed [DataW-1:0] acc_q, acc_d;
  logic                    done_q, done_d;
  logic signed [DataW-1:0] data_q, data_d;
  status_e                 status_q, status_d;

  // RAM ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ValW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [ValW-1:0]  ram_rdata;

  logic                    accept;
  action_e                 act;
  logic [AddrW-1:0]        index_addr;
  logic                    idx_in_range;
  logic [CntW-1:0]         count_m1;
  logic signed [DataW-1:0] rdata_ext;
  logic signed [DataW-1:0] acc_sum;

  assign accept       = start && (state_q == S_IDLE);
  assign act          = action_e'(action_i);
  assign index_addr   = index_i[AddrW-1:0];
  assign idx_in_range = (index_i < count_q);
  assign count_m1     = count_q - CntW'(1);
  assign rdata_ext    = DataW'($signed(ram_rdata));
  assign acc_sum      = acc_q + rdata_ext;

  pars_ram #(
    .Width(ValW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    op_d      = op_q;
    idx_d     = idx_q;
    val_d     = val_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    wr_addr_d = wr_addr_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    data_d    = data_q;
    status_d  = status_q;

    ram_we    = 1'b0;
    ram_waddr = index_addr;
    ram_wdata = value_i;
    ram_raddr = ptr_q;

    // Retire the read issued last cycle: write it one place over, or add it
    if ((state_q == S_RUN || state_q == S_DRAIN) && pend_q) begin
      if (op_q == ACT_SUM) begin
        acc_d = acc_sum;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr_q;
        ram_wdata = ram_rdata;
      end
    end

    case (state_q)
      S_IDLE: begin
        ram_raddr = index_addr;
        if (accept) begin
          // Default: finish at once with zero data and ok status
          done_d   = 1'b1;
          data_d   = '0;
          status_d = ST_OK;
          acc_d    = '0;
          pend_d   = 1'b0;
          op_d     = act;
          idx_d    = index_addr;
          val_d    = value_i;
          case (act)
            ACT_READ: begin
              if (idx_in_range) begin
                // Hold the strobe until the RAM returns the entry
                done_d  = 1'b0;
                state_d = S_RD_WAIT;
              end else begin
                status_d = ST_POS;
              end
            end
            ACT_INSERT: begin
              if (index_i > count_q) begin
                status_d = ST_POS;
              end else if (count_q == CntW'(DEPTH)) begin
                status_d = ST_FULL;
              end else if (index_i == count_q) begin
                // Append: nothing to shift
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                // Shift up, walking down from the last entry
                done_d  = 1'b0;
                ptr_d   = count_m1[AddrW-1:0];
                end_d   = index_addr;
                state_d = S_RUN;
              end
            end
            ACT_ERASE: begin
              if (!idx_in_range) begin
                status_d = ST_POS;
              end else if (index_i == count_m1) begin
                count_d = count_m1;
              end else begin
                // Shift down, walking up from the entry after the hole
                done_d  = 1'b0;
                ptr_d   = index_addr + AddrW'(1);
                end_d   = count_m1[AddrW-1:0];
                state_d = S_RUN;
              end
            end
            ACT_OVERWRITE: begin
              if (idx_in_range) begin
                ram_we = 1'b1;
              end else begin
                status_d = ST_POS;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            ACT_SUM: begin
              if ((index_i > CntW'(right_index_i)) ||
                  (CntW'(right_index_i) >= count_q)) begin
                status_d = ST_RANGE;
              end else begin
                done_d  = 1'b0;
                ptr_d   = index_addr;
                end_d   = right_index_i;
                state_d = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        data_d  = rdata_ext;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_RUN: begin
        // Issue the next read and note where its data goes
        pend_d    = 1'b1;
        wr_addr_d = (op_q == ACT_INSERT) ? ptr_q + AddrW'(1) : ptr_q - AddrW'(1);
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = (op_q == ACT_INSERT) ? ptr_q - AddrW'(1) : ptr_q + AddrW'(1);
        end
      end

      S_DRAIN: begin
        pend_d = 1'b0;
        case (op_q)
          ACT_SUM: begin
            data_d  = acc_sum;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          ACT_INSERT: begin
            state_d = S_INS_WR;
          end
          default: begin
            // Erase: drop the last entry
            count_d = count_m1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_INS_WR: begin
        // Place the new value in the gap left by the shift
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = val_q;
        count_d   = count_q + CntW'(1);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    ptr_q     <= ptr_d;
    end_q     <= end_d;
    wr_addr_q <= wr_addr_d;
    acc_q     <= acc_d;
    data_q    <= data_d;
    status_q  <= status_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign valid_o    = done_q;
  assign data_o     = data_q;
  assign count_o    = count_q;
  assign is_empty_o = (count_q == '0);
  assign status_o   = status_q;

endmodule
`default_nettype wire

[bench/tb_positional_array_range_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_array_range_sum
// Self-checking bench for the positional array with range sum. Items are
// driven as random mixes of all six actions plus the two unused codes. A
// shadow copy of the array predicts every result, and each strobed result is
// compared field by field with the oldest prediction. One phase fills the
// array deep with the most negative value to reach long shifts and large sums.
// ----------------------------------------------------------------------------
module tb_positional_array_range_sum;
  import pars_pkg::*;

  localparam int unsigned DEPTH = 1024;
  // Entries reached by the deep phase
  localparam int unsigned DEEP_FILL = 200;
  // Longest item comes from the deep phase; it and the longest sender gap stay well below this.
  localparam int unsigned STALL_LIMIT = 5000;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One expected result
  typedef struct {
    logic signed [41:0] data;
    logic [10:0]        count;
    logic               is_empty;
    status_e            status;
  } array_reply_t;

  // Shadow copy of the array: predicts replies and checks them in order.
  class array_shadow;
    logic signed [31:0] cells [DEPTH];
    int unsigned        fill;
    array_reply_t       pending [$];
    int unsigned        mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted item to the shadow and queue its reply.
    function void take_item(logic [2:0] act, logic [10:0] idx, logic [9:0] ridx,
                            logic signed [31:0] val);
      array_reply_t       r;
      logic signed [41:0] acc;
      int                 k;
      r.data   = '0;
      r.status = ST_OK;
      case (act)
        ACT_READ: begin
          if (idx < fill) r.data = cells[idx];
          else r.status = ST_POS;
        end
        ACT_INSERT: begin
          // Position check wins over the full check.
          if (idx > fill) begin
            r.status = ST_POS;
          end else if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (k = fill; k > idx; k--) cells[k] = cells[k-1];
            cells[idx] = val;
            fill++;
          end
        end
        ACT_ERASE: begin
          if (idx < fill) begin
            for (k = idx; k + 1 < fill; k++) cells[k] = cells[k+1];
            fill--;
          end else begin
            r.status = ST_POS;
          end
        end
        ACT_OVERWRITE: begin
          if (idx < fill) cells[idx] = val;
          else r.status = ST_POS;
        end
        ACT_CLEAR: fill = 0;
        ACT_SUM: begin
          if (idx > ridx || ridx >= fill) begin
            r.status = ST_RANGE;
          end else begin
            acc = '0;
            for (k = idx; k <= ridx; k++) acc += cells[k];
            r.data = acc;
          end
        end
        default: ;
      endcase
      r.count    = fill[10:0];
      r.is_empty = (fill == 0);
      pending.push_back(r);
    endfunction

    // Compare one strobed result with the oldest prediction.
    function void check_reply(logic signed [41:0] data, logic [10:0] cnt, logic empty,
                              logic [1:0] st);
      array_reply_t e;
      if (pending.size() == 0) begin
        $error("result with no item waiting: data=%0d count=%0d", data, cnt);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (data !== e.data) begin
        $error("data: expected %0d, got %0d", e.data, data);
        mismatches++;
      end
      if (cnt !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, cnt);
        mismatches++;
      end
      if (empty !== e.is_empty) begin
        $error("is_empty: expected %0b, got %0b", e.is_empty, empty);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         action_i;
  logic [10:0]        index_i;
  logic [9:0]         right_index_i;
  logic signed [31:0] value_i;
  logic               valid_o;
  logic signed [41:0] data_o;
  logic [10:0]        count_o;
  logic               is_empty_o;
  logic [1:0]         status_o;

  array_shadow shadow = new();
  int unsigned stall_cycles;

  positional_array_range_sum #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .index_i      (index_i),
    .right_index_i(right_index_i),
    .value_i      (value_i),
    .valid_o      (valid_o),
    .data_o       (data_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Results cannot be held off: check every strobe at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) shadow.check_reply(data_o, count_o, is_empty_o, status_o);
  end

  // Watchdog: count cycles with neither an accepted item nor a result.
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item and hold it until accepted; the shadow takes it on the
  // accept edge, so the caller may read the updated count right away.
  task automatic send_item(input logic [2:0] act, input logic [10:0] idx,
                           input logic [9:0] ridx, input logic signed [31:0] val);
    start         <= 1'b1;
    action_i      <= act;
    index_i       <= idx;
    right_index_i <= ridx;
    value_i       <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    shadow.take_item(act, idx, ridx, val);
  endtask

  // Drop start and scramble the idle fields during a gap; a gap of zero does nothing.
  task automatic hold_off(input int unsigned n);
    if (n > 0) begin
      start         <= 1'b0;
      action_i      <= 3'($urandom);
      index_i       <= 11'($urandom);
      right_index_i <= 10'($urandom);
      value_i       <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Stop sending and wait until every queued reply has come back.
  task automatic drain();
    start <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
  endtask

  // Random mix of actions. Positions are mostly legal; the array is kept
  // near or below cap entries so that shifts and sums stay short.
  task automatic mixed_phase(input int unsigned n_items, input int unsigned cap,
                             input bit bursty);
    int unsigned done;
    int unsigned sel;
    int unsigned cnt;
    int unsigned lo;
    int unsigned hi;
    logic [2:0]  act;
    logic [10:0] idx;
    logic [9:0]  ridx;
    done = 0;
    while (done < n_items) begin
      cnt  = shadow.fill;
      sel  = $urandom_range(0, 99);
      idx  = 11'($urandom);
      ridx = 10'($urandom);
      if (sel < 4) begin
        // Unused codes do nothing; they do not count as work.
        act = $urandom_range(0, 1) ? 3'd6 : 3'd7;
      end else begin
        done++;
        if (sel < 20) act = ACT_READ;
        else if (sel < 46) act = (cnt > cap) ? ACT_ERASE : ACT_INSERT;
        else if (sel < 60) act = (cnt < cap / 4) ? ACT_INSERT : ACT_ERASE;
        else if (sel < 73) act = ACT_OVERWRITE;
        else if (sel < 97) act = ACT_SUM;
        else act = ACT_CLEAR;
        if ($urandom_range(0, 99) < 86) begin
          case (act)
            ACT_INSERT: idx = 11'($urandom_range(0, cnt));
            ACT_SUM: begin
              if (cnt > 0) begin
                lo = $urandom_range(0, cnt - 1);
                if ($urandom_range(0, 9) == 0) hi = cnt - 1;
                else hi = $urandom_range(lo, (lo + 12 < cnt) ? lo + 12 : cnt - 1);
                // Occasionally flip the range to left beyond right.
                if (lo > 0 && $urandom_range(0, 19) == 0) hi = lo - 1;
                idx  = 11'(lo);
                ridx = 10'(hi);
              end
            end
            default: if (cnt > 0) idx = 11'($urandom_range(0, cnt - 1));
          endcase
        end
      end
      send_item(act, idx, ridx, pick_value());
      if (!bursty) hold_off(pick_gap());
    end
  endtask

  // Fill the array deep with the most negative value, then probe long shifts,
  // large negative sums and the position errors at that size.
  task automatic deep_phase();
    int unsigned top;
    while (shadow.fill < DEEP_FILL) begin
      send_item(ACT_INSERT, 11'(shadow.fill), '0, VAL_MIN);
      if ($urandom_range(0, 15) == 0) hold_off($urandom_range(1, 3));
    end
    top = shadow.fill - 1;
    send_item(ACT_SUM, 11'd0, 10'(top), '0);
    send_item(ACT_INSERT, 11'(top + 2), '0, VAL_MAX);
    send_item(ACT_INSERT, 11'd0, '0, VAL_MAX);
    send_item(ACT_READ, 11'(top + 1), '0, '0);
    hold_off(pick_gap());
    send_item(ACT_OVERWRITE, 11'(top + 1), '0, VAL_MAX);
    send_item(ACT_OVERWRITE, 11'd0, '0, VAL_MIN);
    send_item(ACT_ERASE, 11'd0, '0, '0);
    hold_off(pick_gap());
    send_item(ACT_INSERT, 11'd0, '0, pick_value());
    send_item(ACT_SUM, 11'd0, 10'(top + 1), '0);
    send_item(ACT_READ, 11'd1024, '0, '0);
    send_item(ACT_ERASE, 11'(top + 1), '0, '0);
    send_item(ACT_SUM, 11'd0, 10'(top), '0);
    send_item(ACT_CLEAR, '0, '0, '0);
  endtask

  initial begin
    int unsigned ph;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    action_i      <= '0;
    index_i       <= '0;
    right_index_i <= '0;
    value_i       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: every error on the empty array first, then a short sequence
    // that shifts both ways, sums, and uses the unused codes.
    send_item(ACT_READ, 11'd0, '0, '0);
    send_item(ACT_SUM, 11'd0, 10'd0, '0);
    send_item(ACT_ERASE, 11'd0, '0, '0);
    send_item(ACT_OVERWRITE, 11'd0, '0, VAL_MAX);
    send_item(ACT_INSERT, 11'd1, '0, VAL_MAX);
    send_item(ACT_INSERT, 11'd2047, '0, '0);
    send_item(ACT_INSERT, 11'd0, '0, VAL_MAX);
    hold_off(2);
    send_item(ACT_INSERT, 11'd0, '0, VAL_MIN);
    send_item(ACT_INSERT, 11'd2, '0, -32'sd1);
    send_item(ACT_INSERT, 11'd1, '0, 32'sh1234_5678);
    send_item(ACT_READ, 11'd0, '0, '0);
    send_item(ACT_READ, 11'd3, '0, '0);
    send_item(ACT_READ, 11'd4, '0, '0);
    hold_off(5);
    send_item(ACT_OVERWRITE, 11'd2, '0, 32'sh5A5A_5A5A);
    send_item(ACT_SUM, 11'd0, 10'd3, '0);
    send_item(ACT_SUM, 11'd2, 10'd1, '0);
    send_item(ACT_SUM, 11'd1, 10'd4, '0);
    send_item(ACT_ERASE, 11'd1, '0, '0);
    send_item(ACT_ERASE, 11'd2, '0, '0);
    send_item(3'd6, 11'd0, 10'd1023, VAL_MAX);
    send_item(3'd7, 11'd2047, 10'd1023, VAL_MIN);
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_READ, 11'd0, '0, '0);
    send_item(ACT_SUM, 11'd0, 10'd1023, '0);

    // Random phases of varied size limits; some run back to back, and after
    // several the sender waits until every reply is in.
    for (ph = 0; ph < 8; ph++) begin
      mixed_phase(40, $urandom_range(8, 96), ($urandom_range(0, 2) == 0));
      if (ph == 0 || $urandom_range(0, 2) == 0) drain();
    end
    deep_phase();
    mixed_phase(20, 32, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
